### rtl/core/ktis_pkg.sv
// ----------------------------------------------------------------------------
// ktis_pkg
// shared types and codes for the key table insert and search block
// ----------------------------------------------------------------------------
package ktis_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_NOTF  = 2'd2;

  localparam logic [1:0] SM_BINARY = 2'd0;
  localparam logic [1:0] SM_LINEAR = 2'd1;
  localparam logic [1:0] SM_TRANS  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [1:0] CFG_ORDERED  = 2'd0;
  localparam logic [1:0] CFG_METHOD   = 2'd1;
  localparam logic [1:0] CFG_CAPACITY = 2'd2;

  localparam int FIELD_W = 11;

  // datapath commands
  typedef enum logic [3:0] {
    DC_NONE,
    DC_LOAD,     // capture request, init lo/hi/index
    DC_RD_IDX,   // read entry at index-1
    DC_RD_MID,   // read entry at binary midpoint, index to midpoint+1
    DC_BIN_STEP, // update lo/hi from compared entry
    DC_LIN_STEP, // read entry at index, advance index
    DC_SHIFT,    // write read entry one slot up, step down
    DC_PUT_KEY,  // write key at index, bump entry count
    DC_RD_PREV,  // read entry at index-2, the one before the found key
    DC_SWAP_A,   // write previous entry at index-1
    DC_SWAP_B    // write key at index-2
  } dp_cmd_t;

  typedef struct packed {
    logic key_zero;
    logic full;
    logic empty;
    logic idx_zero;    // index is zero
    logic idx_one;     // index is one
    logic lin_end;     // index reached entry count
    logic bin_done;    // lo > hi
    logic rd_eq;       // read data equals key
    logic rd_gt;       // read data above key
  } dp_status_t;

endpackage

### rtl/core/ktis_datapath.sv
// ----------------------------------------------------------------------------
// ktis_datapath
// key memory, search pointers, counters and result registers
// ----------------------------------------------------------------------------
module ktis_datapath #(
  parameter int DEPTH     = 1024,
  parameter int KEY_WIDTH = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ktis_pkg::dp_cmd_t       cmd,
  input  logic                    in_op,
  input  logic [KEY_WIDTH-1:0]    in_key,
  input  logic [10:0]             capacity,
  input  logic                    res_load,
  input  logic [1:0]              res_status,
  input  logic                    res_use_cnt,
  input  logic                    res_use_pos,
  input  logic                    res_pos_dec,
  output ktis_pkg::dp_status_t    status,
  output logic                    op_q,
  output logic [1:0]              out_status_q,
  output logic [10:0]             out_count_q,
  output logic [10:0]             out_position_q
);
  import ktis_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1; // signed lo/hi

  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rd_r, key_r;
  logic [CW-1:0]        cnt_r, idx_r, steps_r;
  logic signed [SW-1:0] lo_r, hi_r;
  logic signed [SW-1:0] msum;
  logic [CW-1:0]        mid;
  logic [CW-1:0]        lim;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 we;
  logic [KEY_WIDTH-1:0] wd;
  logic                 op_r;

  // capacity saturates at depth
  assign lim  = (32'(capacity) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(capacity);
  assign msum = lo_r + ((hi_r - lo_r) >>> 1);
  assign mid  = msum[CW-1:0];

  always_comb begin
    rd_addr = idx_r[AW-1:0];
    we      = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wd      = key_r;
    case (cmd)
      DC_RD_MID:  rd_addr = mid[AW-1:0];
      DC_RD_IDX:  rd_addr = AW'(idx_r - 1'b1);
      DC_RD_PREV: rd_addr = AW'(idx_r - 2'd2);
      DC_SHIFT:   begin we = 1'b1; wd = rd_r; end
      DC_PUT_KEY: we = 1'b1;
      DC_SWAP_A:  begin we = 1'b1; wr_addr = AW'(idx_r - 1'b1); wd = rd_r; end
      DC_SWAP_B:  begin we = 1'b1; wr_addr = AW'(idx_r - 2'd2); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wd;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd == DC_PUT_KEY) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // binary search keeps index at midpoint+1, the 1-based probe position
  always_ff @(posedge clk) begin
    case (cmd)
      DC_LOAD: begin
        key_r   <= in_key;
        op_r    <= in_op;
        lo_r    <= '0;
        hi_r    <= $signed({1'b0, cnt_r}) - SW'(1);
        idx_r   <= (in_op == OP_INSERT) ? cnt_r : '0;
        steps_r <= '0;
      end
      DC_RD_MID: begin
        idx_r   <= mid + 1'b1;
        steps_r <= steps_r + 1'b1;
      end
      DC_BIN_STEP: begin
        if (rd_r < key_r) lo_r <= $signed({1'b0, idx_r});
        else              hi_r <= $signed({1'b0, idx_r}) - SW'(2);
      end
      DC_LIN_STEP: begin
        idx_r   <= idx_r + 1'b1;
        steps_r <= steps_r + 1'b1;
      end
      DC_SHIFT: begin
        idx_r   <= idx_r - 1'b1;
        steps_r <= steps_r + 1'b1;
      end
      default: ;
    endcase
  end

  // linear search: index advanced past the read entry, so found pos is idx
  always_comb begin
    status.key_zero = (key_r == '0);
    status.full     = (cnt_r >= lim);
    status.empty    = (cnt_r == '0);
    status.idx_zero = (idx_r == '0);
    status.idx_one  = (idx_r == CW'(1));
    status.lin_end  = (idx_r >= cnt_r);
    status.bin_done = (lo_r > hi_r);
    status.rd_eq    = (rd_r == key_r);
    status.rd_gt    = (rd_r > key_r);
  end
  assign op_q = op_r;

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_q   <= res_status;
      out_count_q    <= res_use_cnt ? 11'(steps_r) : 11'd0;
      out_position_q <= res_use_pos ?
                        (res_pos_dec ? 11'(idx_r - 1'b1) : 11'(idx_r)) : 11'd0;
    end
  end

endmodule

### rtl/core/ktis_ctrl.sv
// ----------------------------------------------------------------------------
// ktis_ctrl
// sequencer for insert, binary search and linear search
// ----------------------------------------------------------------------------
module ktis_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 ordered_mode,
  input  logic [1:0]           search_method,
  input  ktis_pkg::dp_status_t status,
  input  logic                 op_q,
  output ktis_pkg::dp_cmd_t    cmd,
  output logic                 res_load,
  output logic [1:0]           res_status,
  output logic                 res_use_cnt,
  output logic                 res_use_pos,
  output logic                 res_pos_dec
);
  import ktis_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INS_RD, S_INS_CMP, S_BIN_RD, S_BIN_CMP,
    S_LIN_RD, S_LIN_CMP, S_SWAP_B, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // input is taken whenever no request is in flight and the result slot frees
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = DC_NONE;
    res_load      = 1'b0;
    res_status    = ST_OK;
    res_use_cnt   = 1'b0;
    res_use_pos   = 1'b0;
    res_pos_dec   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd       = DC_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.key_zero) begin
          res_load = 1'b1; res_status = ST_ERR; state_nxt = S_DONE;
        end else if (op_q == OP_INSERT) begin
          if (status.full) begin
            res_load = 1'b1; res_status = ST_ERR; state_nxt = S_DONE;
          end else if (ordered_mode && !status.idx_zero) begin
            cmd = DC_RD_IDX; state_nxt = S_INS_CMP;
          end else begin
            cmd = DC_PUT_KEY; res_load = 1'b1; res_use_cnt = 1'b1;
            state_nxt = S_DONE;
          end
        end else if (search_method == SM_BINARY) begin
          state_nxt = S_BIN_RD;
        end else if (search_method == SM_LINEAR || search_method == SM_TRANS) begin
          if (status.empty) begin
            res_load = 1'b1; res_status = ST_ERR; state_nxt = S_DONE;
          end else begin
            cmd = DC_LIN_STEP; state_nxt = S_LIN_CMP;
          end
        end else begin
          res_load = 1'b1; res_status = ST_ERR; state_nxt = S_DONE;
        end
      end
      S_INS_CMP: begin
        if (status.rd_gt) begin
          cmd = DC_SHIFT; state_nxt = S_INS_RD;
        end else begin
          cmd = DC_PUT_KEY; res_load = 1'b1; res_use_cnt = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_INS_RD: begin
        if (status.idx_zero) begin
          cmd = DC_PUT_KEY; res_load = 1'b1; res_use_cnt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd = DC_RD_IDX; state_nxt = S_INS_CMP;
        end
      end
      S_BIN_RD: begin
        if (status.bin_done) begin
          res_load = 1'b1; res_status = ST_NOTF; state_nxt = S_DONE;
        end else begin
          cmd = DC_RD_MID; state_nxt = S_BIN_CMP;
        end
      end
      S_BIN_CMP: begin
        if (status.rd_eq) begin
          res_load = 1'b1; res_use_cnt = 1'b1; res_use_pos = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd = DC_BIN_STEP; state_nxt = S_BIN_RD;
        end
      end
      S_LIN_CMP: begin
        // idx already points one past the entry just read
        if (status.rd_eq) begin
          if (search_method == SM_TRANS && !status.idx_one) begin
            cmd = DC_RD_PREV; state_nxt = S_LIN_RD;
          end else begin
            res_load = 1'b1; res_use_cnt = 1'b1; res_use_pos = 1'b1;
            state_nxt = S_DONE;
          end
        end else if (status.lin_end) begin
          res_load = 1'b1; res_status = ST_NOTF; state_nxt = S_DONE;
        end else begin
          cmd = DC_LIN_STEP; state_nxt = S_LIN_CMP;
        end
      end
      S_LIN_RD: begin
        cmd       = DC_SWAP_A;
        state_nxt = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd = DC_SWAP_B;
        res_load = 1'b1; res_use_cnt = 1'b1; res_use_pos = 1'b1; res_pos_dec = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> state_r == S_DONE)
    else $error("result dropped");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == DC_LOAD) |=> state_r == S_DECODE) else $error("load lost");

endmodule

### rtl/core/key_table_insert_and_search.sv
// ----------------------------------------------------------------------------
// key_table_insert_and_search
// fixed capacity key table with ordered insert and binary or linear search
// ----------------------------------------------------------------------------
// channel | ports                                | dir
// in      | in_valid in_ready in_op in_key       | request in
// out     | out_valid out_ready out_status/count/position | result out
// cfg     | cfg_we cfg_index cfg_data            | register write
//
// an item is accepted and decoded, walks the table, then waits in the result slot:
// ordered insert reads and shifts each larger key one slot up, then writes the key
// linear search compares one key at a time, then a read and two writes for a swap
// binary search reads and compares one midpoint per probe until found or lo > hi
// the key memory has one read and one write address, one read per compare
// reset clears entry count and loads config defaults; memory is not cleared
// a waiting result holds off the next request; one request at a time
module key_table_insert_and_search #(
  parameter int DEPTH     = 1024,
  parameter int KEY_WIDTH = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [KEY_WIDTH-1:0] in_key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [10:0]          out_count,
  output logic [10:0]          out_position,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [10:0]          cfg_data
);
  import ktis_pkg::*;

  logic        ordered_r;
  logic [1:0]  method_r;
  logic [10:0] capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ordered_r  <= 1'b1;
      method_r   <= SM_BINARY;
      capacity_r <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORDERED:  ordered_r  <= cfg_data[0];
        CFG_METHOD:   method_r   <= cfg_data[1:0];
        CFG_CAPACITY: capacity_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       op_q, res_load, res_use_cnt, res_use_pos, res_pos_dec;
  logic [1:0] res_status;

  ktis_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .ordered_mode(ordered_r), .search_method(method_r), .status, .op_q,
    .cmd, .res_load, .res_status, .res_use_cnt, .res_use_pos, .res_pos_dec
  );

  ktis_datapath #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .in_op, .in_key, .capacity(capacity_r),
    .res_load, .res_status, .res_use_cnt, .res_use_pos, .res_pos_dec,
    .status, .op_q, .out_status_q(out_status), .out_count_q(out_count),
    .out_position_q(out_position)
  );

endmodule

### tb/ktis_checker.sv
// ----------------------------------------------------------------------------
// ktis_checker
// watches the request, result and register ports of the key table, keeps its
// own copy of the table and compares every result with the predicted one
// ----------------------------------------------------------------------------
module ktis_checker #(
  parameter int DEPTH     = 1024,
  parameter int KEY_WIDTH = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_op,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [1:0]           out_status,
  input  logic [10:0]          out_count,
  input  logic [10:0]          out_position,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [10:0]          cfg_data,
  output int                   mismatch_count,
  output int                   pending_results,
  output int                   checked_results
);
  import ktis_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] count;
    logic [10:0] position;
  } lookup_result_t;

  logic [KEY_WIDTH-1:0] key_copy [DEPTH];
  int unsigned          stored_keys;
  logic                 keep_sorted;
  logic [1:0]           method;
  logic [10:0]          table_limit;
  lookup_result_t       awaited_q[$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
    checked_results = 0;
  end

  function automatic lookup_result_t make_result(int st, int cnt, int pos);
    lookup_result_t r;
    r.status   = st[1:0];
    r.count    = cnt[10:0];
    r.position = pos[10:0];
    return r;
  endfunction

  task automatic insert_key(input logic [KEY_WIDTH-1:0] key, output lookup_result_t r);
    int unsigned lim;
    int unsigned slot;
    int          shifts;
    lim    = (table_limit > DEPTH) ? DEPTH : table_limit;
    shifts = 0;
    if (stored_keys >= lim || stored_keys >= DEPTH) begin
      r = make_result(ST_ERR, 0, 0);
    end else begin
      slot = stored_keys;
      if (keep_sorted) begin
        while (slot > 0 && key_copy[slot-1] > key) begin
          key_copy[slot] = key_copy[slot-1];
          slot--;
          shifts++;
        end
      end
      key_copy[slot] = key;
      stored_keys++;
      r = make_result(ST_OK, shifts, 0);
    end
  endtask

  task automatic binary_lookup(input logic [KEY_WIDTH-1:0] key, output lookup_result_t r);
    int lo;
    int hi;
    int mid;
    int probes;
    lo     = 0;
    hi     = int'(stored_keys) - 1;
    probes = 0;
    r      = make_result(ST_NOTF, 0, 0);
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      probes++;
      if (key_copy[mid] == key) begin
        r = make_result(ST_OK, probes, mid + 1);
        break;
      end
      if (key_copy[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
  endtask

  task automatic linear_lookup(input logic [KEY_WIDTH-1:0] key, input bit transpose,
                               output lookup_result_t r);
    int unsigned          i;
    logic [KEY_WIDTH-1:0] held;
    if (stored_keys == 0) begin
      r = make_result(ST_ERR, 0, 0);
    end else begin
      i = 0;
      while (i < stored_keys && key_copy[i] != key) i++;
      if (i >= stored_keys) begin
        r = make_result(ST_NOTF, 0, 0);
      end else if (!transpose || i == 0) begin
        r = make_result(ST_OK, i + 1, i + 1);
      end else begin
        // found key moves one step toward the front
        held          = key_copy[i];
        key_copy[i]   = key_copy[i-1];
        key_copy[i-1] = held;
        r = make_result(ST_OK, i + 1, i);
      end
    end
  endtask

  task automatic predict_request(input logic op, input logic [KEY_WIDTH-1:0] key,
                                 output lookup_result_t r);
    if (key == '0) r = make_result(ST_ERR, 0, 0);
    else if (op == OP_INSERT) insert_key(key, r);
    else if (method == SM_BINARY) binary_lookup(key, r);
    else if (method == SM_LINEAR) linear_lookup(key, 1'b0, r);
    else if (method == SM_TRANS) linear_lookup(key, 1'b1, r);
    else r = make_result(ST_ERR, 0, 0);
  endtask

  always @(posedge clk) begin
    lookup_result_t predicted;
    lookup_result_t seen;
    lookup_result_t want;
    if (!rst_n) begin
      stored_keys = 0;
      keep_sorted = 1'b1;
      method      = SM_BINARY;
      table_limit = 11'd1024;
      awaited_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORDERED:  keep_sorted = cfg_data[0];
          CFG_METHOD:   method      = cfg_data[1:0];
          CFG_CAPACITY: table_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_request(in_op, in_key, predicted);
        awaited_q.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        seen.status   = out_status;
        seen.count    = out_count;
        seen.position = out_position;
        if (awaited_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: status %0d count %0d position %0d",
                     seen.status, seen.count, seen.position);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = awaited_q.pop_front();
          if (want != seen) begin
            if (mismatch_count < 10)
              $display("mismatch: expected status %0d count %0d position %0d, got %0d %0d %0d",
                       want.status, want.count, want.position,
                       seen.status, seen.count, seen.position);
            mismatch_count <= mismatch_count + 1;
          end
          checked_results <= checked_results + 1;
        end
      end
    end
    pending_results <= awaited_q.size();
  end

endmodule

### tb/key_table_insert_and_search_tb.sv
// ----------------------------------------------------------------------------
// key_table_insert_and_search_tb
// drives inserts and searches into the key table under changing register
// settings, with random gaps on both channels; the checker does the scoring
// ----------------------------------------------------------------------------
module key_table_insert_and_search_tb;
  import ktis_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int KEY_WIDTH   = 31;
  localparam int STALL_LIMIT = 20000;  // idle cycles tolerated between handshakes
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 50;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_op = OP_INSERT;
  logic [KEY_WIDTH-1:0] in_key = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [1:0]           out_status;
  logic [10:0]          out_count;
  logic [10:0]          out_position;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = CFG_ORDERED;
  logic [10:0]          cfg_data = '0;

  int                   mismatch_count;
  int                   pending_results;
  int                   checked_results;
  bit                   gaps_on = 1'b1;   // random idling on both sides
  int                   ready_hold = 0;
  int                   quiet_cycles = 0;
  int                   requests_sent = 0;
  int                   settings_used = 0;
  logic [KEY_WIDTH-1:0] key_pool[$];      // nonzero insert keys offered so far, reused by later requests

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  key_table_insert_and_search #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_top (.*);

  ktis_checker #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_checker (.*);

  // random result side backpressure while gaps are on
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: no handshake on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one request, held until accepted; optional idle burst first
  task automatic send_request(input logic op, input logic [KEY_WIDTH-1:0] key);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_key   <= key;
    if (op == OP_INSERT && key != '0) key_pool.push_back(key);
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // drain everything, then let the block settle before register writes
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0 || out_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // all three registers, one per cycle, only while idle
  task automatic set_registers(input logic ordered, input logic [1:0] method,
                               input logic [10:0] cap);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ORDERED;
    cfg_data  <= {10'd0, ordered};
    @(posedge clk);
    cfg_index <= CFG_METHOD;
    cfg_data  <= {9'd0, method};
    @(posedge clk);
    cfg_index <= CFG_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly small keys and reused ones so searches hit, plus zero and extremes
  function automatic logic [KEY_WIDTH-1:0] pick_key();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return {KEY_WIDTH{1'b1}};
    if (r == 2) return KEY_WIDTH'($urandom());
    if (r <= 8 && key_pool.size() > 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return KEY_WIDTH'($urandom_range(1, 200));
  endfunction

  function automatic logic [10:0] pick_capacity();
    case ($urandom_range(0, 7))
      0: return 11'd1;
      1: return 11'd2047;  // saturates to the table depth
      2: return 11'd0;     // every insert reports full
      3: return 11'($urandom_range(2, 64));
      default: return 11'd1024;
    endcase
  endfunction

  initial begin
    logic [1:0] method;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: binary search is not found, linear searches are errors
    send_request(OP_SEARCH, 31'd9);
    set_registers(1'b1, SM_LINEAR, 11'd1024);
    send_request(OP_SEARCH, 31'd9);
    set_registers(1'b1, SM_TRANS, 11'd1024);
    send_request(OP_SEARCH, 31'd9);
    set_registers(1'b1, 2'd3, 11'd1024);   // unused method
    send_request(OP_SEARCH, 31'd9);

    // zero key on both operations, then an ordered fill with extremes
    set_registers(1'b1, SM_BINARY, 11'd1024);
    send_request(OP_INSERT, '0);
    send_request(OP_SEARCH, '0);
    send_request(OP_INSERT, {KEY_WIDTH{1'b1}});
    send_request(OP_INSERT, 31'd1);
    send_request(OP_INSERT, 31'd5);
    send_request(OP_INSERT, 31'd3);
    send_request(OP_SEARCH, 31'd3);
    send_request(OP_SEARCH, {KEY_WIDTH{1'b1}});
    send_request(OP_SEARCH, 31'd7);

    // transposition: repeated hits walk a key toward the front
    set_registers(1'b1, SM_TRANS, 11'd1024);
    send_request(OP_SEARCH, {KEY_WIDTH{1'b1}});
    send_request(OP_SEARCH, {KEY_WIDTH{1'b1}});
    send_request(OP_SEARCH, 31'd1);

    // capacity below the fill level: inserts fail, searches see every key
    set_registers(1'b0, SM_LINEAR, 11'd3);
    send_request(OP_INSERT, 31'd2);
    send_request(OP_SEARCH, 31'd5);
    set_registers(1'b0, SM_BINARY, 11'd0);
    send_request(OP_INSERT, 31'd2);

    // appended, unsorted keys under binary search
    set_registers(1'b0, SM_BINARY, 11'd2047);
    send_request(OP_INSERT, 31'd2);
    send_request(OP_SEARCH, 31'd2);
    send_request(OP_SEARCH, 31'd1);

    // random phases, each under a fresh register setting
    for (int p = 0; p < PHASES; p++) begin
      method = $urandom_range(0, 7) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      set_registers(1'($urandom_range(0, 1)), method, pick_capacity());
      gaps_on = (p < PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request($urandom_range(0, 9) < 4 ? OP_INSERT : OP_SEARCH, pick_key());
    end

    wait_idle();
    repeat (20) @(posedge clk);

    $display("run covered %0d requests over %0d register settings, %0d results checked",
             requests_sent, settings_used, checked_results);
    $display("mismatches seen: %0d", mismatch_count);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
